[sv/windowed_moving_average_unit_defines.svh]
// Assertion helpers for the moving average unit.
`ifndef WINDOWED_MOVING_AVERAGE_UNIT_DEFINES_SVH
`define WINDOWED_MOVING_AVERAGE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define WMA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define WMA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[sv/wma_pkg.sv]
package wma_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned WIN_W    = 7;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd64;

  // func field encoding
  localparam logic FUNC_CLEAR = 1'b1;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef enum logic [0:0] {
    OP_ADD   = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef struct packed {
    op_e                        op;
    logic signed [SAMPLE_W-1:0] sample;
  } cmd_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    logic [COUNT_W-1:0]         fill_count;
  } res_t;

endpackage

[sv/windowed_moving_average_unit.sv]
// Channel | Dir | Handshake                 | Beat payload
// in      | in  | in_valid_i / in_ready_o   | func_i, sample_i (Q8.8)
// out     | out | out_valid_o / out_ready_i | average_o (Q8.8), fill_count_o
// cfg     | in  | cfg_valid_i / cfg_ready_o | window_size_i
//
// Add beat: the ring and sum are updated, then the result is set by the
// bit-serial divider that takes one quotient bit per cycle.
// Clear beat: no divide. The single-port ring is read once and written once
// per add. rst_ni (async, active low) empties the ring and sets window 64.
// A two-deep command queue keeps taking beats while the back end works, and
// the output register lets the back end finish while a result is stalled.
`include "windowed_moving_average_unit_defines.svh"

module windowed_moving_average_unit import wma_pkg::*; #(
  parameter int unsigned WINDOW_MAX = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       func_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] average_o,
  output logic [COUNT_W-1:0]         fill_count_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [WIN_W-1:0]           window_size_i
);

  // largest window the 7-bit register can select
  localparam int unsigned EFF_MAX = (WINDOW_MAX < 127) ? WINDOW_MAX : 127;
  localparam int unsigned IW      = $clog2(WINDOW_MAX);
  // exact sum of up to EFF_MAX signed 16-bit samples
  localparam int unsigned SUM_W   = SAMPLE_W + $clog2(EFF_MAX);

  logic [WIN_W-1:0] win_q;
  logic [WIN_W-1:0] win_eff;
  logic             cfg_fire;
  logic             cmd_valid, cmd_ready;
  cmd_t             cmd;
  logic             res_valid, res_ready;
  res_t             res;
  logic             out_valid_q;
  res_t             out_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WINDOW_RESET;
    end else if (cfg_fire) begin
      win_q <= window_size_i;
    end
  end

  // zero acts as one; anything beyond the ring depth is clamped
  always_comb begin
    if (win_q == '0) begin
      win_eff = WIN_W'(1);
    end else if (win_q > WIN_W'(EFF_MAX)) begin
      win_eff = WIN_W'(EFF_MAX);
    end else begin
      win_eff = win_q;
    end
  end

  wma_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .sample_i    (sample_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  wma_back #(
    .WINDOW_MAX (WINDOW_MAX),
    .IW         (IW),
    .SUM_W      (SUM_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .win_i       (win_eff),
    .cfg_clear_i (cfg_fire),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign average_o    = out_q.average;
  assign fill_count_o = out_q.fill_count;

  `WMA_ASSERT_NOW(a_fill_in_window, clk_i, rst_ni, out_valid_q, out_q.fill_count <= win_eff, "fill count beyond window")
  `WMA_ASSERT_NOW(a_empty_zero, clk_i, rst_ni, out_valid_q && out_q.fill_count == '0, out_q.average == '0, "non-zero average with empty window")
  `WMA_ASSERT_NEXT(a_out_drains, clk_i, rst_ni, out_valid_q && out_ready_i && !res_valid, !out_valid_q, "output register did not drain")

endmodule

[sv/wma_front.sv]
module wma_front import wma_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       func_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       cmd_valid_o,
  input  logic                       cmd_ready_i,
  output cmd_t                       cmd_o
);

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  cmd_t              in_cmd;
  logic              push, pop;

  // classify the incoming beat
  always_comb begin
    in_cmd.op     = (func_i == FUNC_CLEAR) ? OP_CLEAR : OP_ADD;
    in_cmd.sample = sample_i;
  end

  assign in_ready_o  = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_cmd;
    end
  end

endmodule

[sv/wma_div.sv]
module wma_div import wma_pkg::*; #(
  parameter int unsigned DW = 22
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [DW-1:0]       dividend_i,
  input  logic [COUNT_W-1:0]         divisor_i,
  output logic                       done_o,
  output logic signed [SAMPLE_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(DW);

  logic [DW-1:0]      mag_q;
  logic [COUNT_W-1:0] rem_q;
  logic [COUNT_W-1:0] div_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               neg_q;
  logic               busy_q;
  logic               done_q;
  logic [COUNT_W:0]   rem_sh;
  logic [COUNT_W:0]   diff;
  logic               qbit;

  // one restoring step per cycle on the magnitude
  always_comb begin
    rem_sh = {rem_q, mag_q[DW-1]};
    diff   = rem_sh - {1'b0, div_q};
    qbit   = (rem_sh >= {1'b0, div_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= dividend_i[DW-1] ? $unsigned(-dividend_i) : $unsigned(dividend_i);
      neg_q <= dividend_i[DW-1];
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      mag_q <= {mag_q[DW-2:0], qbit};
      rem_q <= qbit ? diff[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(mag_q[SAMPLE_W-1:0]) : $signed(mag_q[SAMPLE_W-1:0]);

endmodule

[sv/wma_back.sv]
module wma_back import wma_pkg::*; #(
  parameter int unsigned WINDOW_MAX = 64,
  parameter int unsigned IW         = 6,
  parameter int unsigned SUM_W      = 22
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [WIN_W-1:0] win_i,
  input  logic             cfg_clear_i,
  input  logic             cmd_valid_i,
  output logic             cmd_ready_o,
  input  cmd_t             cmd_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output res_t             res_o
);

  localparam int unsigned CW = (IW > WIN_W) ? IW : WIN_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_UPD   = 3'd1;
  localparam logic [2:0] S_DIVST = 3'd2;
  localparam logic [2:0] S_DIVW  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                 state_q, state_d;
  logic [SAMPLE_W-1:0]        ring_q [WINDOW_MAX];
  logic signed [SAMPLE_W-1:0] rd_q;
  logic signed [SAMPLE_W-1:0] smp_q;
  logic [IW-1:0]              idx_q;
  logic [IW-1:0]              cur_q;
  logic [COUNT_W-1:0]         count_q;
  logic signed [SUM_W-1:0]    sum_q;
  logic signed [SAMPLE_W-1:0] avg_q;
  logic [IW-1:0]              idx_eff;
  logic [CW-1:0]              idx_inc;
  logic signed [SAMPLE_W-1:0] old_smp;
  logic signed [SUM_W-1:0]    sum_nx;
  logic                       take;
  logic                       div_start;
  logic                       div_done;
  logic signed [SAMPLE_W-1:0] div_quot;

  assign take        = (state_q == S_IDLE) && cmd_valid_i;
  assign cmd_ready_o = (state_q == S_IDLE);
  assign div_start   = (state_q == S_DIVST);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = '{average: avg_q, fill_count: count_q};

  always_comb begin
    idx_eff = (CW'(idx_q) >= CW'(win_i)) ? '0 : idx_q;
    idx_inc = CW'(cur_q) + 1'b1;
    // ring entries are written in order from zero, so the entry about to be
    // overwritten holds a live sample only once the ring has filled
    old_smp = (count_q == win_i) ? rd_q : '0;
    sum_nx  = sum_q - {{(SUM_W-SAMPLE_W){old_smp[SAMPLE_W-1]}}, old_smp}
                    + {{(SUM_W-SAMPLE_W){smp_q[SAMPLE_W-1]}}, smp_q};
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          state_d = (cmd_i.op == OP_CLEAR) ? S_DONE : S_UPD;
        end
      end
      S_UPD:   state_d = S_DIVST;
      S_DIVST: state_d = S_DIVW;
      S_DIVW: begin
        if (div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      count_q <= '0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      if (take && cmd_i.op == OP_CLEAR) begin
        idx_q   <= '0;
        count_q <= '0;
        sum_q   <= '0;
      end
      if (state_q == S_UPD) begin
        sum_q <= sum_nx;
        idx_q <= (idx_inc >= CW'(win_i)) ? '0 : idx_inc[IW-1:0];
        if (count_q < win_i) begin
          count_q <= count_q + 1'b1;
        end
      end
      if (cfg_clear_i) begin
        idx_q   <= '0;
        count_q <= '0;
        sum_q   <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      rd_q  <= ring_q[idx_eff];
      cur_q <= idx_eff;
      smp_q <= cmd_i.sample;
      if (cmd_i.op == OP_CLEAR) begin
        avg_q <= '0;
      end
    end
    if (state_q == S_UPD) begin
      ring_q[cur_q] <= smp_q;
    end
    if (div_done) begin
      avg_q <= div_quot;
    end
  end

  wma_div #(
    .DW(SUM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

endmodule
